FILE: src/icimp_pkg.sv
`default_nettype none

package icimp_pkg;

  // Fixed field widths.
  localparam int VELOCITY_WIDTH = 32;
  localparam int MASS_WIDTH     = 32;
  localparam int NORM_W         = 16;
  localparam int REST_W         = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_RESTITUTION = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_MODE      = 1'd1;
  localparam logic [REST_W-1:0]      RESTITUTION_ONE     = 16'd32768;

  // Pipeline depth: one input stage, 31 root/ratio steps, 15 normal steps,
  // and nine arithmetic stages.
  localparam int NSTAGE = 56;

  typedef struct packed {
    logic signed [VELOCITY_WIDTH-1:0] vel_a_x;
    logic signed [VELOCITY_WIDTH-1:0] vel_a_y;
    logic signed [VELOCITY_WIDTH-1:0] vel_a_z;
    logic signed [VELOCITY_WIDTH-1:0] vel_b_x;
    logic signed [VELOCITY_WIDTH-1:0] vel_b_y;
    logic signed [VELOCITY_WIDTH-1:0] vel_b_z;
    logic signed [NORM_W-1:0]         normal_x;
    logic signed [NORM_W-1:0]         normal_y;
    logic signed [NORM_W-1:0]         normal_z;
    logic [MASS_WIDTH-1:0]            mass_a;
    logic [MASS_WIDTH-1:0]            mass_b;
    logic [REST_W-1:0]                other_restitution;
  } in_t;

  typedef struct packed {
    logic signed [VELOCITY_WIDTH-1:0] delta_a_x;
    logic signed [VELOCITY_WIDTH-1:0] delta_a_y;
    logic signed [VELOCITY_WIDTH-1:0] delta_a_z;
    logic signed [VELOCITY_WIDTH-1:0] delta_b_x;
    logic signed [VELOCITY_WIDTH-1:0] delta_b_y;
    logic signed [VELOCITY_WIDTH-1:0] delta_b_z;
    logic                             degenerate;
  } out_t;

endpackage

`default_nettype wire

FILE: src/icimp_datapath.sv
`default_nettype none

module icimp_datapath (
  input  logic                          clk,
  input  logic                          en,
  input  icimp_pkg::in_t                in_data,
  input  logic [icimp_pkg::REST_W-1:0]  own_restitution,
  input  logic                          plane_mode,
  output icimp_pkg::out_t               out_data
);
  import icimp_pkg::*;

  localparam int DV_W      = 46;
  localparam int F_W       = 18;
  localparam int RAD_W     = 60;
  localparam int SQ_REM_W  = 32;
  localparam int ROOT_W    = 30;
  localparam int SUM_W     = MASS_WIDTH + 1;
  localparam int RATIO_W   = 31;
  localparam int ND_REM_W  = 30;
  localparam int ND_Q_W    = 15;
  localparam int SP_W      = 32 + F_W;
  localparam int UP_W      = 32 + RATIO_W;
  localparam int OP_W      = 32 + NORM_W;
  localparam logic [63:0] DV_CAP = (64'd1 << DV_W) - 64'd1;
  localparam int FIRST_ROOT = 1;
  localparam int LAST_ROOT  = 30;
  localparam int LAST_RATIO = 31;
  localparam int LAST_NORM  = 46;

  // Everything one transaction carries down the pipeline.
  typedef struct packed {
    logic [2:0]                 dv_neg;
    logic [2:0][DV_W-1:0]       dv_mag;
    logic [2:0][NORM_W-1:0]     n_raw;
    logic                       plane;
    logic [F_W-1:0]             f;
    logic                       mass_zero;
    logic [RAD_W-1:0]           sq_rad;
    logic [SQ_REM_W-1:0]        sq_rem;
    logic [ROOT_W-1:0]          sq_root;
    logic [SUM_W-1:0]           msum;
    logic [1:0][SUM_W-1:0]      md_rem;
    logic [1:0][RATIO_W-1:0]    md_num;
    logic [1:0][RATIO_W-1:0]    md_q;
    logic [1:0][ND_REM_W-1:0]   nd_rem;
    logic [1:0][ND_Q_W-1:0]     nd_q;
    logic [2:0][NORM_W-1:0]     nmag;
    logic [2:0]                 nneg;
    logic                       degen;
    logic [2:0][63:0]           term;
    logic                       dneg;
    logic [63:0]                dmag;
    logic [1:0][SP_W-1:0]       sp;
    logic [63:0]                s;
    logic [1:0][1:0][UP_W-1:0]  up;
    logic [1:0][63:0]           u;
    logic [5:0][1:0][OP_W-1:0]  op;
    out_t                       res;
  } item_t;

  item_t st [NSTAGE];

  function automatic logic [NORM_W-1:0] nabs(input logic [NORM_W-1:0] v);
    return v[NORM_W-1] ? NORM_W'(-v) : v;
  endfunction

  // Sign and capped magnitude of b - a.
  function automatic logic [DV_W:0] dv_of(input logic [VELOCITY_WIDTH-1:0] a,
                                          input logic [VELOCITY_WIDTH-1:0] b);
    logic [VELOCITY_WIDTH:0] diff;
    logic [VELOCITY_WIDTH:0] magw;
    logic [63:0]             mag64;
    diff  = {b[VELOCITY_WIDTH-1], b} - {a[VELOCITY_WIDTH-1], a};
    magw  = diff[VELOCITY_WIDTH] ? (~diff + 1'b1) : diff;
    mag64 = 64'(magw);
    if (mag64 > DV_CAP) mag64 = DV_CAP;
    return {diff[VELOCITY_WIDTH], mag64[DV_W-1:0]};
  endfunction

  // Saturated two's complement of a sign and magnitude.
  function automatic logic [VELOCITY_WIDTH-1:0] encode(input logic neg,
                                                       input logic [63:0] mag);
    logic [63:0] lim;
    logic [63:0] m;
    lim = 64'd1 << (VELOCITY_WIDTH - 1);
    m = mag;
    if (neg) begin
      if (m > lim) m = lim;
      m = 64'd0 - m;
    end else begin
      if (m > lim - 64'd1) m = lim - 64'd1;
    end
    return m[VELOCITY_WIDTH-1:0];
  endfunction

  // Input stage: velocity differences, squared XY length, restitution, mass sum.
  function automatic item_t first(input in_t d, input logic [REST_W-1:0] own,
                                  input logic plane);
    item_t y;
    logic [DV_W:0] dv0, dv1, dv2;
    logic signed [31:0] sx, sy;
    logic [31:0] l2;
    logic [31:0] kp;
    y = '0;
    dv0 = dv_of(d.vel_a_x, d.vel_b_x);
    dv1 = dv_of(d.vel_a_y, d.vel_b_y);
    dv2 = dv_of(d.vel_a_z, d.vel_b_z);
    y.dv_neg = {dv2[DV_W], dv1[DV_W], dv0[DV_W]};
    y.dv_mag[0] = dv0[DV_W-1:0];
    y.dv_mag[1] = dv1[DV_W-1:0];
    y.dv_mag[2] = dv2[DV_W-1:0];
    y.n_raw[0] = d.normal_x;
    y.n_raw[1] = d.normal_y;
    y.n_raw[2] = d.normal_z;
    y.plane = plane;
    sx = {{16{d.normal_x[NORM_W-1]}}, d.normal_x};
    sy = {{16{d.normal_y[NORM_W-1]}}, d.normal_y};
    l2 = 32'(sx * sx) + 32'(sy * sy);
    y.sq_rad = {l2, 28'd0};
    kp = 32'(own) * 32'(d.other_restitution);
    y.f = F_W'(32'd32768 + (kp >> 15));
    y.mass_zero = (d.mass_a == '0) || (d.mass_b == '0);
    y.msum = SUM_W'(d.mass_a) + SUM_W'(d.mass_b);
    y.md_rem[0] = SUM_W'(d.mass_b >> 1);
    y.md_num[0] = {d.mass_b[0], 30'd0};
    y.md_rem[1] = SUM_W'(d.mass_a >> 1);
    y.md_num[1] = {d.mass_a[0], 30'd0};
    return y;
  endfunction

  // Work of pipeline stage s on the transaction that leaves stage s-1.
  function automatic item_t step(input int s, input item_t x);
    item_t y;
    logic [SUM_W:0] t;
    logic [SQ_REM_W+1:0] tr;
    logic [SQ_REM_W-1:0] trial;
    logic [ND_REM_W:0] tn;
    logic signed [63:0] dot;
    logic [81:0] ps;
    logic [95:0] pu;
    logic [79:0] po;
    logic [63:0] m;
    logic neg;
    logic [2:0][VELOCITY_WIDTH-1:0] ea, eb;
    logic [61:0] pm;
    y = x;
    if (s >= FIRST_ROOT && s <= LAST_RATIO) begin
      // One bit of each mass ratio per stage.
      for (int k = 0; k < 2; k++) begin
        t = {x.md_rem[k], x.md_num[k][RATIO_W-1]};
        if (t >= {1'b0, x.msum}) begin
          y.md_rem[k] = SUM_W'(t - {1'b0, x.msum});
          y.md_q[k] = {x.md_q[k][RATIO_W-2:0], 1'b1};
        end else begin
          y.md_rem[k] = t[SUM_W-1:0];
          y.md_q[k] = {x.md_q[k][RATIO_W-2:0], 1'b0};
        end
        y.md_num[k] = {x.md_num[k][RATIO_W-2:0], 1'b0};
      end
      // One bit of the XY length root per stage.
      if (s <= LAST_ROOT) begin
        tr = {x.sq_rem, x.sq_rad[RAD_W-1:RAD_W-2]};
        trial = {x.sq_root, 2'b01};
        if (tr >= (SQ_REM_W+2)'(trial)) begin
          y.sq_rem = SQ_REM_W'(tr - (SQ_REM_W+2)'(trial));
          y.sq_root = {x.sq_root[ROOT_W-2:0], 1'b1};
        end else begin
          y.sq_rem = tr[SQ_REM_W-1:0];
          y.sq_root = {x.sq_root[ROOT_W-2:0], 1'b0};
        end
        y.sq_rad = {x.sq_rad[RAD_W-3:0], 2'b00};
      end
      // The root is complete here; seed the normal quotients.
      if (s == LAST_RATIO) begin
        for (int k = 0; k < 2; k++) begin
          y.nd_rem[k] = ND_REM_W'({nabs(x.n_raw[k]), 13'd0});
          y.nd_q[k] = '0;
        end
      end
    end else if (s > LAST_RATIO && s <= LAST_NORM) begin
      // One bit of each plane-normal quotient per stage.
      for (int k = 0; k < 2; k++) begin
        tn = {x.nd_rem[k], 1'b0};
        if (tn >= (ND_REM_W+1)'(x.sq_root)) begin
          y.nd_rem[k] = ND_REM_W'(tn - (ND_REM_W+1)'(x.sq_root));
          y.nd_q[k] = {x.nd_q[k][ND_Q_W-2:0], 1'b1};
        end else begin
          y.nd_rem[k] = tn[ND_REM_W-1:0];
          y.nd_q[k] = {x.nd_q[k][ND_Q_W-2:0], 1'b0};
        end
      end
    end else if (s == LAST_NORM + 1) begin
      // Pick the normal in use and decide degeneracy.
      for (int k = 0; k < 2; k++) begin
        if (x.plane) begin
          if (x.sq_root == '0) y.nmag[k] = '0;
          else if (x.nd_q[k] > ND_Q_W'(16384)) y.nmag[k] = 16'd16384;
          else y.nmag[k] = NORM_W'(x.nd_q[k]);
        end else begin
          y.nmag[k] = nabs(x.n_raw[k]);
        end
      end
      y.nmag[2] = x.plane ? '0 : nabs(x.n_raw[2]);
      for (int k = 0; k < 3; k++) y.nneg[k] = x.n_raw[k][NORM_W-1];
      y.degen = x.mass_zero || (y.nmag == '0);
    end else if (s == LAST_NORM + 2) begin
      // Dot product terms.
      for (int k = 0; k < 3; k++) begin
        pm = {16'd0, x.dv_mag[k]} * {46'd0, x.nmag[k]};
        neg = x.dv_neg[k] ^ x.nneg[k];
        y.term[k] = neg ? (64'd0 - 64'(pm)) : 64'(pm);
      end
    end else if (s == LAST_NORM + 3) begin
      dot = $signed(x.term[0]) + $signed(x.term[1]) + $signed(x.term[2]);
      y.dneg = dot[63];
      y.dmag = dot[63] ? (64'd0 - dot) : dot;
    end else if (s == LAST_NORM + 4) begin
      // Restitution factor, split into two partial products.
      y.sp[0] = SP_W'(x.dmag[31:0]) * SP_W'(x.f);
      y.sp[1] = SP_W'(x.dmag[63:32]) * SP_W'(x.f);
    end else if (s == LAST_NORM + 5) begin
      ps = (82'(x.sp[1]) << 32) + 82'(x.sp[0]);
      y.s = (|ps[81:79]) ? '1 : ps[78:15];
    end else if (s == LAST_NORM + 6) begin
      // Mass ratios, split into partial products.
      for (int a = 0; a < 2; a++) begin
        y.up[a][0] = UP_W'(x.s[31:0]) * UP_W'(x.md_q[a]);
        y.up[a][1] = UP_W'(x.s[63:32]) * UP_W'(x.md_q[a]);
      end
    end else if (s == LAST_NORM + 7) begin
      for (int a = 0; a < 2; a++) begin
        pu = (96'(x.up[a][1]) << 32) + 96'(x.up[a][0]);
        y.u[a] = (|pu[95:94]) ? '1 : pu[93:30];
      end
    end else if (s == LAST_NORM + 8) begin
      // Scale by each normal component.
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 3; k++) begin
          y.op[a*3+k][0] = OP_W'(x.u[a][31:0]) * OP_W'(x.nmag[k]);
          y.op[a*3+k][1] = OP_W'(x.u[a][63:32]) * OP_W'(x.nmag[k]);
        end
      end
    end else if (s == LAST_NORM + 9) begin
      // Sum, apply signs, saturate, and clear on zero components or degeneracy.
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 3; k++) begin
          po = (80'(x.op[a*3+k][1]) << 32) + 80'(x.op[a*3+k][0]);
          m = 64'(po >> 28);
          neg = (x.dneg != x.nneg[k]) ^ (a == 1);
          ea[k] = encode(neg, m);
          if (x.nmag[k] == '0 || x.degen) ea[k] = '0;
          if (a == 0) eb[k] = ea[k];
        end
      end
      // eb holds side a, ea holds side b after the loop.
      y.res.delta_a_x = eb[0];
      y.res.delta_a_y = eb[1];
      y.res.delta_a_z = eb[2];
      y.res.delta_b_x = ea[0];
      y.res.delta_b_y = ea[1];
      y.res.delta_b_z = ea[2];
      y.res.degenerate = x.degen;
    end
    return y;
  endfunction

  // Whole pipeline advances together.
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= first(in_data, own_restitution, plane_mode);
      for (int s = 1; s < NSTAGE; s++) begin
        st[s] <= step(s, st[s-1]);
      end
    end
  end

  assign out_data = st[NSTAGE-1].res;

endmodule

`default_nettype wire

FILE: src/inelastic_collision_impulse_unit.sv
// Contact impulse unit. Each input transaction describes one contact: both
// velocities (Q16.16), the impact normal (Q2.14), both masses and the other
// body's restitution (Q1.15). The output transaction carries the velocity
// changes of both bodies (saturated Q16.16) and a degenerate flag that is set,
// with all deltas zero, when a mass or the used normal is zero.
// Channels use valid/ready; a transaction moves when both are high.
// One transaction is accepted every cycle unless the output stalls. The
// depth comes from the bit-serial root of the XY length and the two mass
// ratios (31 stages), the plane normal quotients (15 stages) and the split
// wide multiplies.
// Configuration (own_restitution, plane_mode) is written through cfg_wr_en,
// cfg_index and cfg_data; the user must write it only while no transaction is in flight (not enforced).
// Synchronous reset empties the pipeline and sets own_restitution to 1.0 and
// plane_mode to 0. When the receiver holds out_ready low with a result
// waiting, the whole pipeline freezes and in_ready drops; nothing is lost.
`default_nettype none

module inelastic_collision_impulse_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  icimp_pkg::in_t                     in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output icimp_pkg::out_t                    out_data,
  input  logic                               cfg_wr_en,
  input  logic [icimp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [icimp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import icimp_pkg::*;

  logic [REST_W-1:0] own_restitution;
  logic              plane_mode;
  logic [NSTAGE-1:0] vld;
  logic              en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_restitution <= RESTITUTION_ONE;
      plane_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OWN_RESTITUTION: own_restitution <= cfg_data[REST_W-1:0];
        REG_PLANE_MODE:      plane_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished result is blocked.
  assign en = !vld[NSTAGE-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[NSTAGE-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  icimp_datapath u_datapath (
    .clk             (clk),
    .en              (en),
    .in_data         (in_data),
    .own_restitution (own_restitution),
    .plane_mode      (plane_mode),
    .out_data        (out_data)
  );

endmodule

`default_nettype wire

FILE: src/icimp_checker.sv
`default_nettype none

module icimp_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input icimp_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input icimp_pkg::out_t out_data
);
  import icimp_pkg::*;

  // An offered input transaction stays and holds its value until taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transaction changed while waiting");

  // A blocked result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // Input is taken exactly when the output side can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  // Degenerate contacts give zero deltas.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      out_data.delta_a_x == '0 && out_data.delta_a_y == '0 &&
      out_data.delta_a_z == '0 && out_data.delta_b_x == '0 &&
      out_data.delta_b_y == '0 && out_data.delta_b_z == '0)
    else $error("degenerate transaction with nonzero delta");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind inelastic_collision_impulse_unit icimp_checker u_icimp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: sim/inelastic_collision_impulse_unit_test.sv
`default_nettype none

module inelastic_collision_impulse_unit_test;
  import icimp_pkg::*;

  localparam int LATENCY = NSTAGE;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_OWN_RESTITUTION;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copies of the configuration registers.
  logic [REST_W-1:0] restitution_reg = RESTITUTION_ONE;
  logic plane_reg = 1'b0;

  out_t deltas_due[$];
  bit typed_due[$];
  out_t typed_want[$];
  int errors = 0;
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  inelastic_collision_impulse_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Full-width product shifted right, saturating to all ones.
  function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
                                                int sh);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // Sign and magnitude to a saturated velocity word.
  function automatic logic [VELOCITY_WIDTH-1:0] sat_velocity(bit neg, longint unsigned mag);
    longint unsigned lim;
    lim = 64'd1 << (VELOCITY_WIDTH - 1);
    if (neg) begin
      if (mag > lim) mag = lim;
      return VELOCITY_WIDTH'(-mag);
    end
    if (mag > lim - 1) mag = lim - 1;
    return VELOCITY_WIDTH'(mag);
  endfunction

  // Velocity changes of both bodies for one contact under the current registers.
  function automatic out_t contact_deltas(in_t c);
    longint n[3];
    longint unsigned nm[3];
    longint va[3], vb[3];
    longint unsigned l2, len, m, q, mag, dmag, k, s, ma, mb, sum, ra, rb, ua, ub;
    longint dot, dv, term;
    logic [VELOCITY_WIDTH-1:0] da[3], db[3];
    bit neg, dneg;
    out_t r;
    n[0] = c.normal_x; n[1] = c.normal_y; n[2] = c.normal_z;
    va[0] = c.vel_a_x; va[1] = c.vel_a_y; va[2] = c.vel_a_z;
    vb[0] = c.vel_b_x; vb[1] = c.vel_b_y; vb[2] = c.vel_b_z;
    r = '0;
    // Plane mode keeps the XY direction at unit length.
    if (plane_reg) begin
      l2 = n[0] * n[0] + n[1] * n[1];
      len = root64(l2 << 28);
      for (int i = 0; i < 2; i++) begin
        m = (n[i] < 0) ? -n[i] : n[i];
        q = (len != 0) ? (m << 28) / len : 0;
        if (q > 16384) q = 16384;
        n[i] = (n[i] < 0) ? -longint'(q) : longint'(q);
      end
      n[2] = 0;
    end
    for (int i = 0; i < 3; i++) nm[i] = (n[i] < 0) ? -n[i] : n[i];
    ma = c.mass_a;
    mb = c.mass_b;
    if (ma == 0 || mb == 0 || (n[0] == 0 && n[1] == 0 && n[2] == 0)) begin
      r.degenerate = 1'b1;
      return r;
    end
    // Relative normal speed as an exact Q.30 dot product.
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      dv = vb[i] - va[i];
      neg = dv < 0;
      mag = neg ? -dv : dv;
      if (mag > (64'd1 << 46) - 1) mag = (64'd1 << 46) - 1;
      if (n[i] < 0) neg = !neg;
      term = mag * nm[i];
      dot += neg ? -term : term;
    end
    dneg = dot < 0;
    dmag = dneg ? -dot : dot;
    k = (64'(restitution_reg) * 64'(c.other_restitution)) >> 15;
    s = mul_shift(dmag, 32768 + k, 15);
    while (((ma | mb) >> 32) != 0) begin
      ma >>= 1;
      mb >>= 1;
    end
    sum = ma + mb;
    ra = (mb << 30) / sum;
    rb = (ma << 30) / sum;
    ua = mul_shift(s, ra, 30);
    ub = mul_shift(s, rb, 30);
    for (int i = 0; i < 3; i++) begin
      neg = dneg != (n[i] < 0);
      da[i] = (nm[i] == 0) ? '0 : sat_velocity(neg, mul_shift(ua, nm[i], 28));
      db[i] = (nm[i] == 0) ? '0 : sat_velocity(!neg, mul_shift(ub, nm[i], 28));
    end
    r.delta_a_x = da[0]; r.delta_a_y = da[1]; r.delta_a_z = da[2];
    r.delta_b_x = db[0]; r.delta_b_y = db[1]; r.delta_b_z = db[2];
    return r;
  endfunction

  function automatic in_t contact(int vax, int vay, int vaz, int vbx, int vby, int vbz,
                                  shortint nx, shortint ny, shortint nz,
                                  int unsigned ma, int unsigned mb, int unsigned rest);
    in_t c;
    c.vel_a_x = vax; c.vel_a_y = vay; c.vel_a_z = vaz;
    c.vel_b_x = vbx; c.vel_b_y = vby; c.vel_b_z = vbz;
    c.normal_x = nx; c.normal_y = ny; c.normal_z = nz;
    c.mass_a = ma; c.mass_b = mb;
    c.other_restitution = REST_W'(rest);
    return c;
  endfunction

  function automatic int idle_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] random_velocity();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] random_normal();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3, 4: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] random_mass();
    case ($urandom_range(0, 29))
      0: return 32'd0;
      1, 2: return 32'hffff_ffff;
      3, 4: return 32'd1;
      5, 6, 7, 8, 9, 10: return $urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_contact();
    in_t c;
    c.vel_a_x = random_velocity(); c.vel_a_y = random_velocity();
    c.vel_a_z = random_velocity(); c.vel_b_x = random_velocity();
    c.vel_b_y = random_velocity(); c.vel_b_z = random_velocity();
    c.normal_x = random_normal(); c.normal_y = random_normal();
    c.normal_z = random_normal();
    // Some contacts point straight along z, which is degenerate in plane mode.
    if ($urandom_range(0, 11) == 0) begin
      c.normal_x = '0;
      c.normal_y = '0;
    end
    c.mass_a = random_mass();
    c.mass_b = random_mass();
    c.other_restitution = ($urandom_range(0, 6) == 0) ? REST_W'($urandom)
                                                      : REST_W'($urandom_range(0, 32768));
    return c;
  endfunction

  // Offer one transaction; valid stays high across back-to-back items.
  task automatic send(in_t c, bit typed, out_t want);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_due.push_back(typed);
    typed_want.push_back(want);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid at the edge of the last acceptance, then wait for all results.
  task automatic drain();
    in_valid <= 1'b0;
    wait (deltas_due.size() == 0 && typed_due.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_OWN_RESTITUTION) restitution_reg = val;
    else plane_reg = val[0];
    @(posedge clk);
  endtask

  task automatic compare(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // Record the expected deltas of each accepted input transaction.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      if (typed_due.pop_front()) begin
        deltas_due.push_back(typed_want.pop_front());
      end else begin
        void'(typed_want.pop_front());
        deltas_due.push_back(contact_deltas(in_data));
      end
    end
  end

  // Check each output transaction against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (deltas_due.size() == 0) begin
        $error("unexpected output transaction %h", out_data);
        errors++;
      end else begin
        want = deltas_due.pop_front();
        compare("delta_a_x", want.delta_a_x, out_data.delta_a_x);
        compare("delta_a_y", want.delta_a_y, out_data.delta_a_y);
        compare("delta_a_z", want.delta_a_z, out_data.delta_a_z);
        compare("delta_b_x", want.delta_b_x, out_data.delta_b_x);
        compare("delta_b_y", want.delta_b_y, out_data.delta_b_y);
        compare("delta_b_z", want.delta_b_z, out_data.delta_b_z);
        compare("degenerate", 32'(want.degenerate), 32'(out_data.degenerate));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    int hold;
    int gap;
    if (hold_request) begin
      hold_request = 1'b0;
      hold = HOLD_CYCLES;
      out_ready <= 1'b0;
      while (hold > 0) begin
        @(posedge clk);
        hold--;
      end
    end
    gap = idle_gap();
    out_ready <= (gap == 0);
  end

  // Watchdog on cycles in which no transaction moves.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    out_t zero_deltas;
    out_t flagged;
    out_t unit_push;
    logic [CFG_DATA_W-1:0] settings_rest[6];
    logic settings_plane[6];

    zero_deltas = '0;
    flagged = '0;
    flagged.degenerate = 1'b1;
    unit_push = '0;
    unit_push.delta_a_x = 32'sd65536;
    unit_push.delta_b_x = -32'sd65536;

    // Directed contacts: degenerate cases, extremes and saturation.
    rows.push_back('{contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, flagged});
    rows.push_back('{contact(32'h7fffffff, -1, 5, 32'h80000000, 7, 9, 16384, 0, 0,
                             0, 5, 32768), 1, flagged});
    rows.push_back('{contact(1, 2, 3, 4, 5, 6, 0, 16384, 0, 5, 0, 32768), 1, flagged});
    rows.push_back('{contact(1, 2, 3, 40, 50, 60, 0, 0, 0, 3, 7, 32768), 1, flagged});
    rows.push_back('{contact(100, 200, 300, 100, 200, 300, 16384, 0, 0, 1, 1, 32768),
                     1, zero_deltas});
    rows.push_back('{contact(0, 0, 0, 65536, 0, 0, 16384, 0, 0, 1, 1, 32768),
                     1, unit_push});
    rows.push_back('{contact(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff, 32767, 32767, 32767,
                             1, 32'hffffffff, 65535), 0, zero_deltas});
    rows.push_back('{contact(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                             32'h80000000, 32'h80000000, -32768, -32768, -32768,
                             32'hffffffff, 1, 65535), 0, zero_deltas});
    rows.push_back('{contact(-65536, 0, 0, 65536, 0, 0, 16384, 0, 0,
                             32'hffffffff, 32'hffffffff, 0), 0, zero_deltas});
    rows.push_back('{contact(0, 131072, 0, 0, -131072, 0, 0, -16384, 0, 3, 1, 16384),
                     0, zero_deltas});
    rows.push_back('{contact(12345, -6789, 4242, -999, 31337, -77, 9459, 9459, 9459,
                             10, 20, 32768), 0, zero_deltas});
    rows.push_back('{contact(0, 0, 65536, 0, 0, -65536, 100, -200, 30000,
                             1000, 1, 32767), 0, zero_deltas});
    rows.push_back('{contact(-1, -1, -1, 1, 1, 1, -1, -1, -1, 1, 1, 1), 0, zero_deltas});
    rows.push_back('{contact(32'h55555555, 32'haaaaaaaa, 0, 32'haaaaaaaa, 32'h55555555, 0,
                             21845, -10923, 0, 32'h55555555, 32'haaaaaaaa, 43690),
                     0, zero_deltas});

    settings_rest = '{16'd0, 16'd32768, 16'd16384, 16'd32768, 16'd0, 16'd25000};
    settings_plane = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);
    drain();

    // Random phases over several register settings.
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        write_register(REG_OWN_RESTITUTION,
                       (ph == 6) ? CFG_DATA_W'($urandom_range(0, 32768))
                                 : settings_rest[ph - 1]);
        write_register(REG_PLANE_MODE, (ph == 6) ? CFG_DATA_W'($urandom_range(0, 1))
                                                 : CFG_DATA_W'(settings_plane[ph - 1]));
      end
      no_idle = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 10) hold_request = 1'b1;
        send(random_contact(), 1'b0, zero_deltas);
      end
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
src/icimp_pkg.sv
src/icimp_datapath.sv
src/inelastic_collision_impulse_unit.sv
src/icimp_checker.sv
sim/inelastic_collision_impulse_unit_test.sv
